>>> hdl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define CHK_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CHK_IMPLY(lbl, ck, rn, ante, cons)
`define CHK_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> hdl/bcia_pkg.sv
// shared types, register codes and fixed-point helpers
package bcia_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_STEPS = 64 + FRAC_BITS;

  typedef logic signed [31:0] word_t;
  typedef logic signed [32:0] opnd_t;
  typedef logic signed [63:0] sum_t;
  typedef logic signed [65:0] wide_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [30:0] quo;
  } div_res_t;

  localparam logic [2:0] REG_CENTER_X_Y      = 3'd0;
  localparam logic [2:0] REG_CENTER_Z_HALF_X = 3'd1;
  localparam logic [2:0] REG_HALF_Y_Z        = 3'd2;
  localparam logic [2:0] REG_ROT_W_X         = 3'd3;
  localparam logic [2:0] REG_ROT_Y_Z         = 3'd4;
  localparam logic [2:0] REG_FALL_X_Y        = 3'd5;
  localparam logic [2:0] REG_FALL_Z_SKIN     = 3'd6;

  localparam word_t ONE_Q    = word_t'(1) <<< FRAC_BITS;
  localparam word_t WORD_MAX = 32'sh7fffffff;
  localparam word_t WORD_MIN = 32'sh80000000;
  localparam wide_t WIDE_MAX = 66'sd2147483647;
  localparam wide_t WIDE_MIN = -66'sd2147483648;
  localparam sum_t  SUM_MAX  = 64'sh7fffffffffffffff;
  localparam sum_t  SUM_MIN  = 64'sh8000000000000000;

  function automatic word_t sat32(input wide_t v);
    if (v > WIDE_MAX) begin
      return WORD_MAX;
    end else if (v < WIDE_MIN) begin
      return WORD_MIN;
    end
    return v[31:0];
  endfunction

  // product reduction: truncate toward zero, then saturate
  function automatic word_t mulq_red(input wide_t p);
    logic [65:0] m;
    logic [65:0] r;
    m = p[65] ? 66'(-p) : 66'(p);
    r = m >> FRAC_BITS;
    return sat32(p[65] ? -$signed(r) : $signed(r));
  endfunction

  function automatic sum_t add64(input sum_t a, input sum_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      return s[64] ? SUM_MIN : SUM_MAX;
    end
    return s[63:0];
  endfunction

endpackage

>>> hdl/bcia_div.sv
// restoring divider, one quotient bit per cycle, fraction bits appended
`include "assert_macros.svh"
module bcia_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        num,
  input  logic [63:0]        den,
  output bcia_pkg::div_res_t res
);
  import bcia_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [79:0] dvd_r;
  logic [63:0] rem_r;
  logic [63:0] den_r;
  logic [31:0] q_r;
  logic        ovf_r;
  logic [64:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_r, dvd_r[79]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'(DIV_STEPS);
        dvd_r  <= {num, 16'b0};
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
      end else if (busy_r) begin
        rem_r <= ge ? 64'(rem_sh - {1'b0, den_r}) : rem_sh[63:0];
        dvd_r <= {dvd_r[78:0], 1'b0};
        q_r   <= {q_r[30:0], ge};
        ovf_r <= ovf_r | q_r[31];
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r | q_r[31];
  assign res.quo  = q_r[30:0];

  `CHK_IMPLY(a_start_idle, clk, rst_n, start, !busy_r)
  `CHK_NEXT(a_start_busy, clk, rst_n, start, busy_r)
  `CHK_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r && !busy_r)

endmodule

>>> hdl/box_contact_impulse_accumulator.sv
// top level: point versus oriented box contact impulse accumulator
//
// Each vertex runs through one shared 33x33 multiplier under a sequencer: a vertex inside
// the box takes two quaternion rotations of 15 products each plus the push and impulse
// products, a vertex outside adds the squared offset, a 32-step square root and three
// 80-step normal divisions, and a vertex with zero mass skips straight to the end-of-vertex
// step. A last vertex adds three 80-step divisions for the contact point when any vertex
// of the batch made contact. The input is ready only between vertices; a finished result
// waits in the output register while the next vertex runs.
`include "assert_macros.svh"
module box_contact_impulse_accumulator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, dvel_x, dvel_y, dvel_z, mass
  input  logic [223:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // impulse_x, impulse_y, impulse_z, contact_x, contact_y, contact_z
  output logic [191:0] out_tdata,
  // has_contact
  output logic [0:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);
  import bcia_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_ROT, S_GEO, S_SCALE, S_SQ, S_SQRT, S_NORM,
    S_ACC, S_LAST, S_CDIV, S_EMIT
  } state_t;

  logic [63:0] cfg_r [7];
  word_t ctr [3];
  word_t hx [3];
  word_t fall [3];
  word_t qw, qx, qy, qz, skin;

  state_t      state_r;
  logic        phase_r;
  logic [3:0]  step_r;
  logic        rneg_r;
  logic [1:0]  axis_r;
  logic        div_start_r;
  logic        last_r;
  logic [31:0] mass_r;
  word_t       pos_r [3];
  word_t       fs_r [3];
  word_t       vr_r [3];
  word_t       tr_r [3];
  word_t       cr_r [3];
  word_t       rot_r [3];
  word_t       away_r [3];
  word_t       cont_r [3];
  word_t       acc_r, dist_r, push_r, j_r;
  wide_t       prod_r;
  logic [1:0]  sh_r;
  logic [29:0] as_r [3];
  logic [63:0] sum_r;
  logic [63:0] sq_x_r, sq_q_r;
  logic [4:0]  sq_cnt_r;
  sum_t        imp_r [3];
  sum_t        mom_r [3];
  sum_t        wgt_r;
  logic        out_tvalid_r;
  logic [191:0] out_data_r;
  logic        out_user_r;

  opnd_t ma, mb;
  opnd_t ux, uy, uz, uw;
  wide_t prod_nxt;
  word_t mq;
  word_t dg [3];
  word_t awy [3];
  logic  outside;
  logic [1:0] ax;
  logic [31:0] amag [3];
  logic [31:0] amax;
  logic [1:0]  sh_nxt;
  logic [63:0] sq_b, sq_rb;
  logic [63:0] div_num, div_den;
  logic [63:0] mom_mag;
  div_res_t    div_res;
  word_t       qv, pn;

  assign ctr[0]  = cfg_r[REG_CENTER_X_Y][63:32];
  assign ctr[1]  = cfg_r[REG_CENTER_X_Y][31:0];
  assign ctr[2]  = cfg_r[REG_CENTER_Z_HALF_X][63:32];
  assign hx[0]   = cfg_r[REG_CENTER_Z_HALF_X][31:0];
  assign hx[1]   = cfg_r[REG_HALF_Y_Z][63:32];
  assign hx[2]   = cfg_r[REG_HALF_Y_Z][31:0];
  assign qw      = cfg_r[REG_ROT_W_X][63:32];
  assign qx      = cfg_r[REG_ROT_W_X][31:0];
  assign qy      = cfg_r[REG_ROT_Y_Z][63:32];
  assign qz      = cfg_r[REG_ROT_Y_Z][31:0];
  assign fall[0] = cfg_r[REG_FALL_X_Y][63:32];
  assign fall[1] = cfg_r[REG_FALL_X_Y][31:0];
  assign fall[2] = cfg_r[REG_FALL_Z_SKIN][63:32];
  assign skin    = cfg_r[REG_FALL_Z_SKIN][31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_CENTER_X_Y]      <= '0;
      cfg_r[REG_CENTER_Z_HALF_X] <= '0;
      cfg_r[REG_HALF_Y_Z]        <= '0;
      cfg_r[REG_ROT_W_X]         <= {ONE_Q, 32'b0};
      cfg_r[REG_ROT_Y_Z]         <= '0;
      cfg_r[REG_FALL_X_Y]        <= '0;
      cfg_r[REG_FALL_Z_SKIN]     <= '0;
    end else if (cfg_we && (cfg_index <= REG_FALL_Z_SKIN)) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  // rotation axis, conjugated on the way into the box frame
  assign uw = 33'(qw);
  assign ux = rneg_r ? -33'(qx) : 33'(qx);
  assign uy = rneg_r ? -33'(qy) : 33'(qy);
  assign uz = rneg_r ? -33'(qz) : 33'(qz);

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_ROT: begin
        case (step_r)
          4'd0:  begin ma = uy; mb = 33'(vr_r[2]); end
          4'd1:  begin ma = uz; mb = 33'(vr_r[1]); end
          4'd2:  begin ma = uz; mb = 33'(vr_r[0]); end
          4'd3:  begin ma = ux; mb = 33'(vr_r[2]); end
          4'd4:  begin ma = ux; mb = 33'(vr_r[1]); end
          4'd5:  begin ma = uy; mb = 33'(vr_r[0]); end
          4'd6:  begin ma = uy; mb = 33'(tr_r[2]); end
          4'd7:  begin ma = uz; mb = 33'(tr_r[1]); end
          4'd8:  begin ma = uz; mb = 33'(tr_r[0]); end
          4'd9:  begin ma = ux; mb = 33'(tr_r[2]); end
          4'd10: begin ma = ux; mb = 33'(tr_r[1]); end
          4'd11: begin ma = uy; mb = 33'(tr_r[0]); end
          4'd12: begin ma = uw; mb = 33'(tr_r[0]); end
          4'd13: begin ma = uw; mb = 33'(tr_r[1]); end
          4'd14: begin ma = uw; mb = 33'(tr_r[2]); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      S_SQ: begin
        ma = $signed({3'b0, as_r[step_r[1:0]]});
        mb = $signed({3'b0, as_r[step_r[1:0]]});
      end
      S_ACC: begin
        case (step_r)
          4'd0: begin ma = 33'(fs_r[0]); mb = 33'(rot_r[0]); end
          4'd1: begin ma = 33'(fs_r[1]); mb = 33'(rot_r[1]); end
          4'd2: begin ma = 33'(fs_r[2]); mb = 33'(rot_r[2]); end
          4'd3: begin ma = $signed({1'b0, mass_r}); mb = 33'(push_r); end
          4'd4: begin ma = 33'(rot_r[0]); mb = 33'(j_r); end
          4'd5: begin ma = 33'(rot_r[1]); mb = 33'(j_r); end
          4'd6: begin ma = 33'(rot_r[2]); mb = 33'(j_r); end
          4'd7: begin ma = 33'(pos_r[0]); mb = 33'(j_r); end
          4'd8: begin ma = 33'(pos_r[1]); mb = 33'(j_r); end
          4'd9: begin ma = 33'(pos_r[2]); mb = 33'(j_r); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod_nxt = ma * mb;
  assign mq       = mulq_red(prod_r);
  assign pn       = sat32(66'(push_r) + 66'(mq));

  // face distances, clamp offsets and nearest face
  always_comb begin
    opnd_t pa, ph, nh, c1, cc;
    for (int i = 0; i < 3; i++) begin
      ph     = 33'(rot_r[i]);
      pa     = rot_r[i][31] ? -ph : ph;
      dg[i]  = sat32(66'(pa) - 66'(hx[i]));
      nh     = -33'(hx[i]);
      c1     = (ph < nh) ? nh : ph;
      cc     = (c1 > 33'(hx[i])) ? 33'(hx[i]) : c1;
      awy[i] = sat32(66'(ph) - 66'(cc));
    end
    outside = (dg[0] > 0) || (dg[1] > 0) || (dg[2] > 0);
    ax = 2'd0;
    if (dg[1] > dg[0]) ax = 2'd1;
    if (dg[2] > dg[ax]) ax = 2'd2;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag[i] = away_r[i][31] ? 32'(-33'(away_r[i])) : 32'(away_r[i]);
    end
    amax = amag[0];
    if (amag[1] > amax) amax = amag[1];
    if (amag[2] > amax) amax = amag[2];
    sh_nxt = amax[31] ? 2'd2 : (amax[30] ? 2'd1 : 2'd0);
  end

  assign sq_b  = 64'(1) << {sq_cnt_r, 1'b0};
  assign sq_rb = sq_q_r + sq_b;

  assign mom_mag = mom_r[axis_r][63] ? $unsigned(-mom_r[axis_r]) : $unsigned(mom_r[axis_r]);
  assign div_num = (state_r == S_CDIV) ? mom_mag : 64'(as_r[axis_r]);
  assign div_den = (state_r == S_CDIV) ? $unsigned(wgt_r) :
                   ((sq_q_r == '0) ? 64'd1 : sq_q_r);
  assign qv      = $signed({1'b0, div_res.quo});

  bcia_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= 1'b0;
      step_r       <= '0;
      axis_r       <= '0;
      div_start_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
      wgt_r        <= '0;
      for (int i = 0; i < 3; i++) begin
        imp_r[i] <= '0;
        mom_r[i] <= '0;
      end
    end else begin
      div_start_r <= 1'b0;
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if ((state_r == S_ROT) || (state_r == S_SQ) || (state_r == S_ACC)) begin
        phase_r <= ~phase_r;
        if (!phase_r) begin
          prod_r <= prod_nxt;
        end else begin
          step_r <= step_r + 4'd1;
        end
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            for (int i = 0; i < 3; i++) begin
              pos_r[i] <= in_tdata[32*i +: 32];
              fs_r[i]  <= in_tdata[96 + 32*i +: 32];
            end
            mass_r  <= in_tdata[223:192];
            last_r  <= in_tlast;
            state_r <= (in_tdata[223:192] == '0) ? S_LAST : S_PREP;
          end
        end
        S_PREP: begin
          for (int i = 0; i < 3; i++) begin
            vr_r[i] <= sat32(66'(pos_r[i]) - 66'(ctr[i]));
            fs_r[i] <= sat32(66'(fs_r[i]) - 66'(fall[i]));
          end
          rneg_r  <= 1'b1;
          step_r  <= '0;
          phase_r <= 1'b0;
          state_r <= S_ROT;
        end
        S_ROT: begin
          if (phase_r) begin
            case (step_r)
              4'd1:  tr_r[0] <= sat32(66'(sat32(66'(acc_r) - 66'(mq))) * 66'sd2);
              4'd3:  tr_r[1] <= sat32(66'(sat32(66'(acc_r) - 66'(mq))) * 66'sd2);
              4'd5:  tr_r[2] <= sat32(66'(sat32(66'(acc_r) - 66'(mq))) * 66'sd2);
              4'd7:  cr_r[0] <= sat32(66'(acc_r) - 66'(mq));
              4'd9:  cr_r[1] <= sat32(66'(acc_r) - 66'(mq));
              4'd11: cr_r[2] <= sat32(66'(acc_r) - 66'(mq));
              4'd12: rot_r[0] <= sat32(66'(vr_r[0]) + 66'(mq) + 66'(cr_r[0]));
              4'd13: rot_r[1] <= sat32(66'(vr_r[1]) + 66'(mq) + 66'(cr_r[1]));
              4'd14: begin
                rot_r[2] <= sat32(66'(vr_r[2]) + 66'(mq) + 66'(cr_r[2]));
                step_r   <= '0;
                if (rneg_r) begin
                  state_r <= S_GEO;
                end else begin
                  state_r <= (dist_r <= skin) ? S_ACC : S_LAST;
                end
              end
              default: acc_r <= mq;
            endcase
          end
        end
        S_GEO: begin
          for (int i = 0; i < 3; i++) begin
            away_r[i] <= awy[i];
            vr_r[i]   <= '0;
          end
          if (outside) begin
            state_r <= S_SCALE;
          end else begin
            dist_r     <= dg[ax];
            vr_r[ax]   <= rot_r[ax][31] ? -ONE_Q : ONE_Q;
            rneg_r     <= 1'b0;
            step_r     <= '0;
            phase_r    <= 1'b0;
            state_r    <= S_ROT;
          end
        end
        S_SCALE: begin
          for (int i = 0; i < 3; i++) begin
            as_r[i] <= 30'(amag[i] >> sh_nxt);
          end
          sh_r    <= sh_nxt;
          sum_r   <= '0;
          step_r  <= '0;
          phase_r <= 1'b0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          if (phase_r) begin
            sum_r <= sum_r + prod_r[63:0];
            if (step_r == 4'd2) begin
              sq_x_r   <= sum_r + prod_r[63:0];
              sq_q_r   <= '0;
              sq_cnt_r <= 5'd31;
              step_r   <= '0;
              state_r  <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (sq_x_r >= sq_rb) begin
            sq_x_r <= sq_x_r - sq_rb;
            sq_q_r <= (sq_q_r >> 1) + sq_b;
          end else begin
            sq_q_r <= sq_q_r >> 1;
          end
          sq_cnt_r <= sq_cnt_r - 5'd1;
          if (sq_cnt_r == '0) begin
            axis_r      <= '0;
            div_start_r <= 1'b1;
            state_r     <= S_NORM;
          end
        end
        S_NORM: begin
          dist_r <= sat32($signed(66'(sq_q_r) << sh_r));
          if (div_res.done) begin
            vr_r[axis_r] <= away_r[axis_r][31] ? -qv : qv;
            if (axis_r == 2'd2) begin
              rneg_r  <= 1'b0;
              step_r  <= '0;
              phase_r <= 1'b0;
              state_r <= S_ROT;
            end else begin
              axis_r      <= axis_r + 2'd1;
              div_start_r <= 1'b1;
            end
          end
        end
        S_ACC: begin
          if (phase_r) begin
            case (step_r)
              4'd0: push_r <= mq;
              4'd1: push_r <= pn;
              4'd2: begin
                push_r <= pn;
                if (pn <= 0) begin
                  step_r  <= '0;
                  state_r <= S_LAST;
                end
              end
              4'd3: begin
                j_r   <= mq;
                wgt_r <= add64(wgt_r, 64'(mq));
              end
              4'd4: imp_r[0] <= add64(imp_r[0], -64'(mq));
              4'd5: imp_r[1] <= add64(imp_r[1], -64'(mq));
              4'd6: imp_r[2] <= add64(imp_r[2], -64'(mq));
              4'd7: mom_r[0] <= add64(mom_r[0], 64'(mq));
              4'd8: mom_r[1] <= add64(mom_r[1], 64'(mq));
              4'd9: begin
                mom_r[2] <= add64(mom_r[2], 64'(mq));
                step_r   <= '0;
                state_r  <= S_LAST;
              end
              default: push_r <= push_r;
            endcase
          end
        end
        S_LAST: begin
          if (!last_r) begin
            state_r <= S_IDLE;
          end else if (wgt_r > 0) begin
            axis_r      <= '0;
            div_start_r <= 1'b1;
            state_r     <= S_CDIV;
          end else begin
            for (int i = 0; i < 3; i++) begin
              cont_r[i] <= ctr[i];
            end
            state_r <= S_EMIT;
          end
        end
        S_CDIV: begin
          if (div_res.done) begin
            if (mom_r[axis_r][63]) begin
              cont_r[axis_r] <= div_res.ovf ? WORD_MIN : -qv;
            end else begin
              cont_r[axis_r] <= div_res.ovf ? WORD_MAX : qv;
            end
            if (axis_r == 2'd2) begin
              state_r <= S_EMIT;
            end else begin
              axis_r      <= axis_r + 2'd1;
              div_start_r <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_data_r   <= {cont_r[2], cont_r[1], cont_r[0],
                             sat32(66'(imp_r[2])), sat32(66'(imp_r[1])),
                             sat32(66'(imp_r[0]))};
            out_user_r   <= wgt_r > 0;
            out_tvalid_r <= 1'b1;
            wgt_r        <= '0;
            for (int i = 0; i < 3; i++) begin
              imp_r[i] <= '0;
              mom_r[i] <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `CHK_IMPLY(a_done_state, clk, rst_n, div_res.done, (state_r == S_NORM) || (state_r == S_CDIV))
  `CHK_NEXT(a_emit_clear, clk, rst_n, (state_r == S_EMIT) && (!out_tvalid_r || out_tready), out_tvalid_r && (wgt_r == '0))
  `CHK_NEXT(a_skip_massless, clk, rst_n, in_tvalid && in_tready && (in_tdata[223:192] == '0), state_r == S_LAST)

endmodule
